// File: rtl/matvt_pkg.sv
// shared constants, payload types and control structs for the multiturn angle tracker
package matvt_pkg;

  // default configuration of the tracker
  localparam int ANGLE_BITS_DEF = 16;
  localparam int WINDOW_LEN_DEF = 40;

  // fixed field widths
  localparam int RAW_W      = 16;
  localparam int TURN_W     = 32;
  localparam int POS_W      = 48;
  localparam int DELTA_W    = 49;
  localparam int CHANGE_W   = 50;
  localparam int SUM_W      = 56;
  localparam int GAIN_W     = 32;
  localparam int VEL_W      = 32;
  localparam int GAIN_SHIFT = 24;
  localparam int LO_W       = 32;
  localparam int HI_W       = SUM_W - LO_W;

  // input beat
  typedef struct packed {
    logic [RAW_W-1:0] raw_angle;
  } sample_t;

  // output beat
  typedef struct packed {
    logic signed [TURN_W-1:0] turns;
    logic signed [POS_W-1:0]  position_counts;
    logic signed [VEL_W-1:0]  velocity;
  } result_t;

  // stage load enables for the velocity scaler
  typedef struct packed {
    logic ld_mag;
    logic ld_prod;
    logic ld_quot;
    logic ld_out;
  } scale_ctrl_t;

endpackage

// File: rtl/matvt_stream_if.sv
// valid/ready stream interface carrying one payload beat
interface matvt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/multiturn_angle_velocity_tracker.sv
// top level: multiturn angle unwrap with moving-average velocity
//
// Usage:
//   sample  - stream sink, one raw absolute angle per beat; only the low
//             ANGLE_BITS bits count.
//   result  - stream source, one beat per sample: turn count, unwrapped
//             position in counts and Q16.16 velocity in rad/s.
//   cfg_we / cfg_wdata - write of the Q8.24 velocity gain; write it only
//             while no sample is in flight.
// Timing:
//   an accepted sample passes through every pipeline stage in order before its result shows;
//   one sample per cycle is taken when the result side keeps up.
//   The nine pipeline stages each carry their own valid bit, so a stalled
//   result only holds back stages that are full; bubbles still close up.
//   The running window sum update and the split 56x32 gain multiply set
//   the stage count.
// Reset:
//   rst (synchronous) empties the pipeline, disarms the wrap check and
//   zeroes turn count, previous position, the delta window, window sum and
//   gain. The first sample after reset only arms the wrap check.
module multiturn_angle_velocity_tracker #(
  parameter int ANGLE_BITS = matvt_pkg::ANGLE_BITS_DEF,
  parameter int WINDOW_LEN = matvt_pkg::WINDOW_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [matvt_pkg::GAIN_W-1:0] cfg_wdata,
  matvt_stream_if.sink                 sample,
  matvt_stream_if.source               result
);
  import matvt_pkg::*;

  localparam int NS      = 9;
  localparam int HALF_I  = 1 << (ANGLE_BITS - 1);
  localparam logic signed [ANGLE_BITS:0] HALF = (ANGLE_BITS + 1)'(HALF_I);

  logic [NS-1:0] stage_vld;
  logic [NS-1:0] rdy;

  logic [GAIN_W-1:0]     gain;
  logic                  armed;
  logic [ANGLE_BITS-1:0] previous_angle;
  logic signed [TURN_W-1:0] turn_count;
  logic signed [POS_W-1:0]  previous_position;
  logic signed [DELTA_W-1:0] history [WINDOW_LEN];
  logic signed [SUM_W-1:0]  window_sum;

  logic [ANGLE_BITS-1:0]    angle_s0;
  logic signed [TURN_W-1:0] turns_s [1:NS-1];
  logic signed [POS_W-1:0]  pos_s   [1:NS-1];
  logic signed [DELTA_W-1:0]  delta_s2;
  logic signed [DELTA_W-1:0]  oldest_s2;
  logic signed [CHANGE_W-1:0] change_s3;

  logic signed [ANGLE_BITS:0] diff;
  logic signed [TURN_W-1:0]   turn_next;
  logic signed [POS_W-1:0]    turn_ext;
  logic signed [POS_W-1:0]    pos_next;
  logic signed [DELTA_W-1:0]  delta_next;
  logic signed [VEL_W-1:0]    velocity;
  scale_ctrl_t                scale_ctrl;

  logic mv1, mv2, mv4;

  // per-stage ready: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NS-1] = !stage_vld[NS-1] || result.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !stage_vld[k] || rdy[k+1];
    end
  end

  assign sample.ready = rdy[0];
  assign mv1 = rdy[1] && stage_vld[0];
  assign mv2 = rdy[2] && stage_vld[1];
  assign mv4 = rdy[4] && stage_vld[3];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      if (rdy[0]) begin
        stage_vld[0] <= sample.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          stage_vld[k] <= stage_vld[k-1];
        end
      end
    end
  end

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
    end else if (cfg_we) begin
      gain <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      angle_s0 <= sample.payload.raw_angle[ANGLE_BITS-1:0];
    end
  end

  // wrap detection and unwrapped position
  assign diff = signed'({1'b0, angle_s0}) - signed'({1'b0, previous_angle});

  always_comb begin
    turn_next = turn_count;
    if (armed && (diff > HALF)) begin
      turn_next = turn_count - TURN_W'(1);
    end else if (armed && (diff < -HALF)) begin
      turn_next = turn_count + TURN_W'(1);
    end
  end

  assign turn_ext = POS_W'(turn_next);
  assign pos_next = (turn_ext << ANGLE_BITS) | {{(POS_W-ANGLE_BITS){1'b0}}, angle_s0};

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      previous_angle <= '0;
      turn_count     <= '0;
    end else if (mv1) begin
      armed          <= 1'b1;
      previous_angle <= angle_s0;
      turn_count     <= turn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      turns_s[1] <= turn_next;
      pos_s[1]   <= pos_next;
    end
  end

  // position delta and delta window shift line
  assign delta_next = DELTA_W'(pos_s[1]) - DELTA_W'(previous_position);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_position <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        history[i] <= '0;
      end
    end else if (mv2) begin
      previous_position <= pos_s[1];
      history[0]        <= delta_next;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      delta_s2  <= delta_next;
      oldest_s2 <= history[WINDOW_LEN-1];
    end
  end

  // net change of the window
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      change_s3 <= CHANGE_W'(delta_s2) - CHANGE_W'(oldest_s2);
    end
  end

  // running window sum
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
    end else if (mv4) begin
      window_sum <= window_sum + SUM_W'(change_s3);
    end
  end

  // turns and position ride along with the velocity pipeline
  for (genvar k = 2; k < NS; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        turns_s[k] <= turns_s[k-1];
        pos_s[k]   <= pos_s[k-1];
      end
    end
  end

  // velocity scaling
  assign scale_ctrl.ld_mag  = rdy[5];
  assign scale_ctrl.ld_prod = rdy[6];
  assign scale_ctrl.ld_quot = rdy[7];
  assign scale_ctrl.ld_out  = rdy[8];

  matvt_vel_scale u_vel_scale (
    .clk        (clk),
    .ctrl       (scale_ctrl),
    .gain       (gain),
    .window_sum (window_sum),
    .velocity   (velocity)
  );

  // result beat
  assign result.valid                   = stage_vld[NS-1];
  assign result.payload.turns           = turns_s[NS-1];
  assign result.payload.position_counts = pos_s[NS-1];
  assign result.payload.velocity        = velocity;

endmodule

// File: rtl/matvt_vel_scale.sv
// pipelined signed window sum times unsigned gain, shift, floor and saturate
module matvt_vel_scale (
  input  logic                             clk,
  input  matvt_pkg::scale_ctrl_t           ctrl,
  input  logic [matvt_pkg::GAIN_W-1:0]     gain,
  input  logic signed [matvt_pkg::SUM_W-1:0] window_sum,
  output logic signed [matvt_pkg::VEL_W-1:0] velocity
);
  import matvt_pkg::*;

  localparam int PLO_W = LO_W + GAIN_W;
  localparam int PHI_W = HI_W + GAIN_W;
  localparam int Q_W   = 64;
  localparam logic [Q_W-1:0] POS_LIMIT = Q_W'((64'd1 << (VEL_W - 1)) - 64'd1);
  localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(64'd1 << (VEL_W - 1));
  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  logic             neg_m;
  logic [SUM_W-1:0] mag;
  logic             neg_p;
  logic [PLO_W-1:0] plo;
  logic [PHI_W-1:0] phi;
  logic             neg_q;
  logic             rem;
  logic [Q_W-1:0]   quot;
  logic [Q_W-1:0]   quot_next;
  logic [VEL_W-1:0] vel_next;

  // sign and magnitude of the window sum
  always_ff @(posedge clk) begin
    if (ctrl.ld_mag) begin
      neg_m <= window_sum[SUM_W-1];
      mag   <= window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
    end
  end

  // two partial products, low word and high word of the magnitude
  always_ff @(posedge clk) begin
    if (ctrl.ld_prod) begin
      neg_p <= neg_m;
      plo   <= PLO_W'(mag[LO_W-1:0]) * PLO_W'(gain);
      phi   <= PHI_W'(mag[SUM_W-1:LO_W]) * PHI_W'(gain);
    end
  end

  // recombine and shift right by the gain fraction
  assign quot_next = (Q_W'(phi) << (LO_W - GAIN_SHIFT)) + Q_W'(plo[PLO_W-1:GAIN_SHIFT]);

  always_ff @(posedge clk) begin
    if (ctrl.ld_quot) begin
      neg_q <= neg_p;
      rem   <= |plo[GAIN_SHIFT-1:0];
      quot  <= quot_next;
    end
  end

  // floor toward minus infinity and saturate
  always_comb begin
    if (!neg_q) begin
      vel_next = (quot > POS_LIMIT) ? VEL_MAX : quot[VEL_W-1:0];
    end else if ((quot >= NEG_LIMIT) || (rem && (quot == POS_LIMIT))) begin
      vel_next = VEL_MIN;
    end else if (rem) begin
      vel_next = ~quot[VEL_W-1:0];
    end else begin
      vel_next = ~quot[VEL_W-1:0] + VEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      velocity <= vel_next;
    end
  end

endmodule

// File: tb/tb.sv
// self-checking testbench for the multiturn angle tracker with moving-average velocity
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import matvt_pkg::*;

  localparam int ANGLE_BITS  = ANGLE_BITS_DEF;
  localparam int WINDOW_LEN  = WINDOW_LEN_DEF;
  localparam int HALF_REV    = 1 << (ANGLE_BITS - 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 12;

  localparam logic signed [95:0] VEL_MAX = 96'sd2147483647;
  localparam logic signed [95:0] VEL_MIN = -96'sd2147483648;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_BURSTY} rx_mode_e;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [GAIN_W-1:0] cfg_wdata;

  matvt_stream_if #(.payload_t(sample_t)) sample_ch ();
  matvt_stream_if #(.payload_t(result_t)) result_ch ();

  multiturn_angle_velocity_tracker u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .sample   (sample_ch),
    .result   (result_ch)
  );

  // tracker state as predicted
  bit                        trk_armed;
  logic [ANGLE_BITS-1:0]     trk_prev_angle;
  logic [TURN_W-1:0]         trk_turns;
  logic signed [POS_W-1:0]   trk_prev_pos;
  logic signed [DELTA_W-1:0] trk_deltas [WINDOW_LEN];
  logic signed [SUM_W-1:0]   trk_window_sum;
  logic [GAIN_W-1:0]         trk_gain;

  result_t expected_results [$];

  int       err_count;
  int       cycle_count;
  int       samples_sent;
  int       results_checked;
  int       gain_settings;
  int       burst_left;
  bit       sender_gaps;
  rx_mode_e rx_mode;
  logic [ANGLE_BITS-1:0] cur_angle;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // floor((sum * gain) / 2^24), clamped to int32
  function automatic logic signed [VEL_W-1:0] scale_to_velocity(
      input logic signed [SUM_W-1:0] s, input logic [GAIN_W-1:0] g);
    logic signed [95:0] prod;
    logic signed [95:0] q;
    prod = {{(96-SUM_W){s[SUM_W-1]}}, s} * {{(96-GAIN_W){1'b0}}, g};
    q = prod >>> GAIN_SHIFT;
    if (q > VEL_MAX) return VEL_MAX[VEL_W-1:0];
    if (q < VEL_MIN) return VEL_MIN[VEL_W-1:0];
    return q[VEL_W-1:0];
  endfunction

  // one tracker update: unwrap, window push, velocity; queues the expected beat
  task automatic predict_tracker_step(input logic [RAW_W-1:0] raw);
    logic [ANGLE_BITS-1:0]     angle;
    int                        diff;
    logic [63:0]               turns_ext;
    logic signed [POS_W-1:0]   pos;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] oldest;
    result_t                   r;
    angle = raw[ANGLE_BITS-1:0];
    diff = int'(angle) - int'(trk_prev_angle);
    if (trk_armed) begin
      if (diff > HALF_REV) trk_turns = trk_turns - TURN_W'(1);
      else if (diff < -HALF_REV) trk_turns = trk_turns + TURN_W'(1);
    end else begin
      trk_armed = 1'b1;
    end
    trk_prev_angle = angle;

    turns_ext = {{(64-TURN_W){trk_turns[TURN_W-1]}}, trk_turns};
    pos = POS_W'(turns_ext << ANGLE_BITS) + POS_W'(angle);
    delta = {pos[POS_W-1], pos} - {trk_prev_pos[POS_W-1], trk_prev_pos};
    trk_prev_pos = pos;

    oldest = trk_deltas[WINDOW_LEN-1];
    for (int i = WINDOW_LEN - 1; i > 0; i--) trk_deltas[i] = trk_deltas[i-1];
    trk_deltas[0] = delta;
    trk_window_sum = trk_window_sum
                   - {{(SUM_W-DELTA_W){oldest[DELTA_W-1]}}, oldest}
                   + {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};

    r.turns           = trk_turns;
    r.position_counts = pos;
    r.velocity        = scale_to_velocity(trk_window_sum, trk_gain);
    expected_results.push_back(r);
  endtask

  // result beat checker
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.payload;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat turns=%0d pos=%0d vel=%0d",
                                  got.turns, got.position_counts, got.velocity));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.turns !== want.turns)
          report_mismatch($sformatf("result %0d turns got %0d want %0d",
                                    results_checked, got.turns, want.turns));
        if (got.position_counts !== want.position_counts)
          report_mismatch($sformatf("result %0d position got %0d want %0d",
                                    results_checked, got.position_counts,
                                    want.position_counts));
        if (got.velocity !== want.velocity)
          report_mismatch($sformatf("result %0d velocity got %0d want %0d",
                                    results_checked, got.velocity, want.velocity));
      end
    end
  end

  // result ready, stall pattern picked by rx_mode
  initial begin
    int          hold;
    bit          level;
    logic [15:0] pat;
    hold  = 0;
    level = 1'b1;
    pat   = 16'b1011_0111_0010_1111;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (rx_mode)
        RX_ALWAYS: result_ch.ready <= 1'b1;
        RX_RANDOM: result_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: begin
          pat = {pat[14:0], pat[15]};
          result_ch.ready <= pat[0];
        end
        default: begin
          if (hold > 0) begin
            hold--;
          end else begin
            level = !level;
            hold = level ? $urandom_range(0, 12) : $urandom_range(1, 10);
          end
          result_ch.ready <= level;
        end
      endcase
    end
  end

  // drop valid and idle for the requested gap
  task automatic idle_gap(input int n);
    sample_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // offer one sample beat and wait for it to be taken; valid stays high
  task automatic send_sample(input logic [RAW_W-1:0] raw);
    sample_t s;
    s.raw_angle = raw;
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= s;
    do @(posedge clk); while (!sample_ch.ready);
    predict_tracker_step(raw);
    samples_sent++;
  endtask

  // burst pacing on the sample side
  task automatic pace_sender();
    if (!sender_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_gap($urandom_range(1, 7));
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic send_paced(input logic [RAW_W-1:0] raw);
    send_sample(raw);
    pace_sender();
  endtask

  // wait until the pipeline has drained
  task automatic wait_until_idle();
    sample_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we   <= 1'b0;
    trk_gain = g;
    gain_settings++;
  endtask

  // random walk of the shaft; optional noise samples in between
  task automatic run_motion(input int n_items, input bit with_noise);
    int  kind;
    int  step;
    bit  reverse;
    reverse = ($urandom_range(0, 1) != 0);
    for (int i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) reverse = !reverse;
      case (kind)
        0, 1, 2, 3: step = $urandom_range(0, 200);
        4, 5:       step = $urandom_range(200, 20000);
        6, 7:       step = $urandom_range(HALF_REV - 8, HALF_REV + 8);
        default:    step = $urandom_range(0, (1 << ANGLE_BITS) - 1);
      endcase
      if (with_noise && kind == 9)
        cur_angle = ANGLE_BITS'($urandom_range(0, (1 << ANGLE_BITS) - 1));
      else if (reverse) cur_angle = cur_angle - step[ANGLE_BITS-1:0];
      else cur_angle = cur_angle + step[ANGLE_BITS-1:0];
      send_paced(RAW_W'(cur_angle));
    end
  endtask

  // first sample after reset and jumps around half a revolution
  task automatic test_first_sample_and_wraps();
    rx_mode     = RX_RANDOM;
    sender_gaps = 1'b1;
    write_gain(32'h0012_3456);
    send_paced(16'd40000);
    send_paced(16'd40000);
    send_paced(16'd0);
    send_paced(16'd32768);
    send_paced(16'd0);
    send_paced(16'd32769);
    send_paced(16'd0);
    send_paced(16'd65535);
    send_paced(16'd0);
    send_paced(16'd65535);
    send_paced(16'd32767);
    send_paced(16'd65535);
    send_paced(16'd1);
    send_paced(16'hAAAA);
    send_paced(16'h5555);
    send_paced(16'h0001);
    send_paced(16'h8000);
    send_paced(16'h7FFF);
    cur_angle = 16'h7FFF;
  endtask

  // gain at zero, full scale, mid scale and one LSB; fast spin both ways at full scale
  task automatic test_gain_extremes();
    rx_mode = RX_PATTERN;
    write_gain(32'h0000_0000);
    for (int i = 0; i < 6; i++) begin
      cur_angle = cur_angle + 16'd30000;
      send_paced(cur_angle);
    end
    write_gain(32'hFFFF_FFFF);
    for (int i = 0; i < 50; i++) begin
      cur_angle = cur_angle + 16'(HALF_REV - 1);
      send_paced(cur_angle);
    end
    for (int i = 0; i < 50; i++) begin
      cur_angle = cur_angle - 16'(HALF_REV - 1);
      send_paced(cur_angle);
    end
    write_gain(32'h8000_0000);
    for (int i = 0; i < 20; i++) begin
      cur_angle = cur_angle - 16'($urandom_range(1, 3));
      send_paced(cur_angle);
    end
    write_gain(32'h0000_0001);
    run_motion(10, 1'b0);
  endtask

  // back to back samples with no stalls on either side
  task automatic test_steady_spin();
    rx_mode     = RX_ALWAYS;
    sender_gaps = 1'b0;
    write_gain(32'h0100_0000);
    for (int i = 0; i < 45; i++) begin
      cur_angle = cur_angle + 16'($urandom_range(20000, HALF_REV));
      send_paced(cur_angle);
    end
    run_motion(45, 1'b0);
    sender_gaps = 1'b1;
  endtask

  // random motion under every stall pattern and several random gains
  task automatic test_random_motion();
    rx_mode_e modes [4];
    modes = '{RX_RANDOM, RX_BURSTY, RX_PATTERN, RX_ALWAYS};
    for (int ph = 0; ph < 4; ph++) begin
      rx_mode = modes[ph];
      write_gain($urandom());
      run_motion(35, 1'b0);
    end
  endtask

  // raw noise plus broken motion
  task automatic test_noise();
    rx_mode = RX_BURSTY;
    write_gain(32'h00FF_FFFF);
    for (int i = 0; i < 30; i++) send_paced(RAW_W'($urandom_range(0, 65535)));
    rx_mode = RX_RANDOM;
    write_gain(32'hFFFF_FFFF);
    run_motion(40, 1'b1);
  endtask

  // main sequence
  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.payload <= '0;
    cycle_count     = 0;
    err_count       = 0;
    samples_sent    = 0;
    results_checked = 0;
    gain_settings   = 0;
    burst_left      = 0;
    sender_gaps     = 1'b1;
    rx_mode         = RX_ALWAYS;
    cur_angle       = '0;
    trk_armed       = 1'b0;
    trk_prev_angle  = '0;
    trk_turns       = '0;
    trk_prev_pos    = '0;
    trk_window_sum  = '0;
    trk_gain        = '0;
    for (int i = 0; i < WINDOW_LEN; i++) trk_deltas[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_sample_and_wraps();
    test_gain_extremes();
    test_steady_spin();
    test_random_motion();
    test_noise();

    wait_until_idle();
    repeat (20) @(posedge clk);

    $display("run covered %0d samples over %0d gain settings, %0d results checked",
             samples_sent, gain_settings, results_checked);
    $display("final turn count %0d, %0d mismatches", $signed(trk_turns), err_count);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
